// File: src/dma4_pkg.sv
// shared types and constants for the four-channel dma controller
// no dependencies; imported by every module of the block
`default_nettype none

package dma4_pkg;

	localparam int DEF_NUM_CHANNELS = 4;
	localparam int CH_W             = 2;
	localparam int ADDR_W           = 16;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_STATUS = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	localparam logic [3:0] MODE_REG        = 4'd8;
	localparam int         MODE_ROTATE_BIT = 4;
	localparam int         MODE_STOP_BIT   = 6;
	localparam logic [7:0] COUNT_HIGH_MASK = 8'h3f;
	localparam logic [1:0] KIND_NONE       = 2'd3;

	typedef struct packed {
		cmd_t       cmd;
		logic [3:0] reg_index;
		logic [7:0] write_data;
		logic [3:0] request_lines;
	} item_t;

	typedef struct packed {
		logic [7:0]        read_data;
		logic              hold_request;
		logic [CH_W-1:0]   grant_channel;
		logic [ADDR_W-1:0] grant_address;
		logic [1:0]        grant_kind;
		logic              channel_done;
		logic              terminal_count;
	} result_t;

	typedef struct packed {
		logic            hit;
		logic [CH_W-1:0] ch;
		logic [CH_W-1:0] next_turn;
	} grant_t;

endpackage

`default_nettype wire

// File: src/dma4_arb.sv
// channel arbiter: fixed or rotating priority over the requesting channels
// depends on dma4_pkg
`default_nettype none

module dma4_arb import dma4_pkg::*; #(
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
	input  wire logic [NUM_CHANNELS-1:0] wants,
	input  wire logic                    rotate,
	input  wire logic [CH_W-1:0]         next_in_turn,
	output grant_t                       grant
);

	always_comb begin
		logic [CH_W:0] s;
		logic [CH_W:0] j;
		grant = '0;
		grant.next_turn = next_in_turn;
		// walk from lowest priority up so the highest one wins
		for (int k = NUM_CHANNELS - 1; k >= 0; k--) begin
			if (rotate) begin
				s = {1'b0, next_in_turn} + (CH_W+1)'(k);
				j = (s >= (CH_W+1)'(NUM_CHANNELS)) ? s - (CH_W+1)'(NUM_CHANNELS) : s;
			end else begin
				s = (CH_W+1)'(k);
				j = s;
			end
			if (wants[j[CH_W-1:0]]) begin
				grant.hit = 1'b1;
				grant.ch  = j[CH_W-1:0];
				if (rotate) begin
					grant.next_turn = (j == (CH_W+1)'(NUM_CHANNELS - 1)) ? '0
						: CH_W'(j + (CH_W+1)'(1));
				end else begin
					grant.next_turn = next_in_turn;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: src/dma4_core.sv
// channel register file and per-item update logic
// depends on dma4_pkg and dma4_arb
`default_nettype none

module dma4_core import dma4_pkg::*; #(
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step,
	input  wire item_t item,
	output result_t    res
);

	logic [NUM_CHANNELS-1:0] en_q, cmp_q;
	logic [ADDR_W-1:0]       addr_q [NUM_CHANNELS];
	logic [15:0]             rem_q  [NUM_CHANNELS];
	logic [1:0]              kind_q [NUM_CHANNELS];
	logic                    low_next_q, rotate_q, stop_q;
	logic [CH_W-1:0]         turn_q, last_q;

	logic [NUM_CHANNELS-1:0] en_d, cmp_d;
	logic [ADDR_W-1:0]       addr_d [NUM_CHANNELS];
	logic [15:0]             rem_d  [NUM_CHANNELS];
	logic [1:0]              kind_d [NUM_CHANNELS];
	logic                    low_next_d, rotate_d, stop_d;
	logic [CH_W-1:0]         turn_d, last_d;

	logic [NUM_CHANNELS-1:0] wants;
	grant_t                  grant;

	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			wants[i] = en_q[i] & item.request_lines[i];
		end
	end

	dma4_arb #(.NUM_CHANNELS(NUM_CHANNELS)) u_arb (
		.wants        (wants),
		.rotate       (rotate_q),
		.next_in_turn (turn_q),
		.grant        (grant)
	);

	always_comb begin
		logic [2:0] wch;
		logic       reg_ok;
		en_d       = en_q;
		cmp_d      = cmp_q;
		addr_d     = addr_q;
		rem_d      = rem_q;
		kind_d     = kind_q;
		low_next_d = low_next_q;
		rotate_d   = rotate_q;
		stop_d     = stop_q;
		turn_d     = turn_q;
		last_d     = last_q;
		res        = '0;
		res.grant_kind = KIND_NONE;
		wch    = item.reg_index[3:1];
		reg_ok = (item.reg_index < MODE_REG) && (wch < 3'(NUM_CHANNELS));
		unique case (item.cmd)
			CMD_TICK: begin
				if (grant.hit) begin
					turn_d = grant.next_turn;
					last_d = grant.ch;
					res.hold_request  = 1'b1;
					res.grant_channel = grant.ch;
					for (int i = 0; i < NUM_CHANNELS; i++) begin
						if (grant.ch == CH_W'(i)) begin
							res.grant_address = addr_q[i];
							res.grant_kind    = kind_q[i];
							addr_d[i] = addr_q[i] + ADDR_W'(1);
							rem_d[i]  = rem_q[i] - 16'd1;
							if (rem_q[i] == 16'd1) begin
								if (stop_q) en_d[i] = 1'b0;
								cmp_d[i] = 1'b1;
								res.channel_done = 1'b1;
							end
						end
					end
				end
			end
			CMD_WRITE: begin
				if (item.reg_index == MODE_REG) begin
					low_next_d = 1'b1;
					for (int i = 0; i < NUM_CHANNELS; i++) begin
						en_d[i] = item.write_data[i];
					end
					rotate_d = item.write_data[MODE_ROTATE_BIT];
					stop_d   = item.write_data[MODE_STOP_BIT];
				end else if (reg_ok) begin
					low_next_d = !low_next_q;
					for (int i = 0; i < NUM_CHANNELS; i++) begin
						if (wch == 3'(i)) begin
							if (!item.reg_index[0]) begin
								// start address, low byte then high byte
								if (low_next_q) addr_d[i] = {8'h00, item.write_data};
								else addr_d[i] = addr_q[i] | {item.write_data, 8'h00};
							end else if (low_next_q) begin
								rem_d[i] = {8'h00, item.write_data};
							end else begin
								rem_d[i] = (rem_q[i]
									| {item.write_data & COUNT_HIGH_MASK, 8'h00}) + 16'd1;
								kind_d[i] = item.write_data[7:6];
							end
						end
					end
				end
			end
			CMD_STATUS: begin
				res.read_data = 8'(cmp_q);
				cmp_d = '0;
			end
			CMD_NOP: begin
			end
		endcase
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (last_d == CH_W'(i)) res.terminal_count = (rem_d[i] == 16'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q       <= '0;
			cmp_q      <= '0;
			low_next_q <= 1'b1;
			rotate_q   <= 1'b0;
			stop_q     <= 1'b0;
			turn_q     <= '0;
			last_q     <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				addr_q[i] <= '0;
				rem_q[i]  <= 16'hffff;
				kind_q[i] <= KIND_NONE;
			end
		end else if (step) begin
			en_q       <= en_d;
			cmp_q      <= cmp_d;
			low_next_q <= low_next_d;
			rotate_q   <= rotate_d;
			stop_q     <= stop_d;
			turn_q     <= turn_d;
			last_q     <= last_d;
			addr_q     <= addr_d;
			rem_q      <= rem_d;
			kind_q     <= kind_d;
		end
	end

endmodule

`default_nettype wire

// File: src/four_channel_dma_controller.sv
// top level of the four-channel dma controller: request register, core, result register
// depends on dma4_pkg, dma4_core and dma4_arb
`default_nettype none

// 8257-style dma controller with up to four channels. each request on the
// slave side is a service tick, a byte register write or a status read
// (s_tuser) and yields exactly one result on the master side. a request is
// held in an input register, runs through one level of arbitration and
// channel update logic, and lands in a result register, so one request is
// taken every clock while results keep draining. the channel register file is
// updated in the same cycle a request moves into the result register, so
// back-to-back requests always see the state left by the one before. s_tready
// drops only when both the input and result registers are full and the result
// is not being taken.
module four_channel_dma_controller import dma4_pkg::*; #(
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [1:0]  s_tuser,  // command
	input  wire logic [15:0] s_tdata,  // reg_index[3:0], write_data[11:4], request_lines[15:12]
	// result channel
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [1:0]       m_tuser,  // grant_kind
	// read_data[7:0], hold_request[8], grant_channel[10:9], grant_address[26:11],
	// channel_done[27], terminal_count[28], zero pad [31:29]
	output logic [31:0]      m_tdata
);

	// input register
	logic    valid_s1;
	item_t   item_s1;
	// result register
	logic    valid_q;
	result_t res_q;

	result_t res_d;
	logic    adv;

	// request in the input register moves on when the result slot frees up
	assign adv      = valid_s1 && (!valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (s_tvalid && s_tready) begin
			item_s1.cmd           <= cmd_t'(s_tuser);
			item_s1.reg_index     <= s_tdata[3:0];
			item_s1.write_data    <= s_tdata[11:4];
			item_s1.request_lines <= s_tdata[15:12];
		end
	end

	// channel state and the per-request work
	dma4_core #(.NUM_CHANNELS(NUM_CHANNELS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_q <= res_d;
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = res_q.grant_kind;
	assign m_tdata  = {3'b000, res_q.terminal_count, res_q.channel_done,
		res_q.grant_address, res_q.grant_channel, res_q.hold_request, res_q.read_data};

`ifndef SYNTH
	// a stall on the request side means both registers are full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_q))
		else $error("request stalled with a free register");

	// completion pulse only comes with a grant
	a_done_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.channel_done) |-> res_q.hold_request)
		else $error("channel_done without a grant");

	// no grant means no transfer kind and no address
	a_idle_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !res_q.hold_request) |->
		(res_q.grant_kind == KIND_NONE && res_q.grant_address == '0))
		else $error("idle result carries transfer fields");

	// status byte and a grant never share one result
	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.read_data != 8'h00) |-> !res_q.hold_request)
		else $error("status byte on a granted tick");

	// granted channel exists
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.hold_request) |->
		({1'b0, res_q.grant_channel} < (CH_W+1)'(NUM_CHANNELS)))
		else $error("grant to an absent channel");
`endif

endmodule

`default_nettype wire

// File: sim/testbench.sv
// self-checking testbench for four_channel_dma_controller: random and directed requests,
// a shadow of the channel registers predicts every result; depends on dma4_pkg and the rtl
`default_nettype none

module testbench;
	import dma4_pkg::*;

	localparam int NCH = DEF_NUM_CHANNELS;

	// transfer kinds held in the top two bits of the count high byte
	localparam logic [1:0] KIND_VERIFY = 2'd0;

	// mode bits the block ignores
	localparam logic [7:0] MODE_EXT_WRITE = 8'h20;
	localparam logic [7:0] MODE_AUTOLOAD  = 8'h80;

	localparam int PHASE_REQUESTS = 300;

	// shadow of the channel registers plus the queue of results still owed
	class channel_ledger;
		logic [15:0] address[NCH];
		logic [15:0] remaining[NCH];
		logic [1:0]  kind[NCH];
		bit          enabled[NCH];
		bit          completed[NCH];
		bit          low_next;
		bit          rotating;
		bit          stopping;
		int          turn;
		int          last;
		result_t     owed[$];
		int          errors;
		int          n_grants;
		int          n_done;
		int          n_status;

		function new();
			for (int i = 0; i < NCH; i++) begin
				address[i]   = '0;
				remaining[i] = 16'hffff;
				kind[i]      = KIND_NONE;
				enabled[i]   = 0;
				completed[i] = 0;
			end
			low_next = 1;
			rotating = 0;
			stopping = 0;
			turn     = 0;
			last     = 0;
		endfunction

		function void write_register(logic [3:0] idx, logic [7:0] d);
			int ch;
			ch = idx >> 1;
			if (idx == MODE_REG) begin
				low_next = 1;
				for (int i = 0; i < NCH; i++)
					enabled[i] = d[i];
				rotating = d[MODE_ROTATE_BIT];
				stopping = d[MODE_STOP_BIT];
				return;
			end
			if (idx > MODE_REG || ch >= NCH)
				return;
			if (!idx[0]) begin
				if (low_next)
					address[ch] = {8'h00, d};
				else
					address[ch] = address[ch] | {d, 8'h00};
			end else begin
				if (low_next) begin
					remaining[ch] = {8'h00, d};
				end else begin
					remaining[ch] = (remaining[ch] | {d & COUNT_HIGH_MASK, 8'h00}) + 16'd1;
					kind[ch] = d[7:6];
				end
			end
			low_next = !low_next;
		endfunction

		function void note_request(cmd_t c, logic [3:0] idx, logic [7:0] d, logic [3:0] rq);
			result_t r;
			int      sel;
			int      j;
			r = '0;
			r.grant_kind = KIND_NONE;
			case (c)
				CMD_TICK: begin
					sel = -1;
					for (int i = 0; i < NCH; i++) begin
						j = rotating ? (i + turn) % NCH : i;
						if (sel < 0 && enabled[j] && rq[j])
							sel = j;
					end
					if (sel >= 0) begin
						if (rotating)
							turn = (sel + 1) % NCH;
						r.hold_request  = 1'b1;
						r.grant_channel = sel[1:0];
						r.grant_address = address[sel];
						r.grant_kind    = kind[sel];
						address[sel]    = address[sel] + 16'd1;
						remaining[sel]  = remaining[sel] - 16'd1;
						if (remaining[sel] == 16'd0) begin
							if (stopping)
								enabled[sel] = 0;
							completed[sel] = 1;
							r.channel_done = 1'b1;
							n_done++;
						end
						last = sel;
						n_grants++;
					end
				end
				CMD_WRITE: write_register(idx, d);
				CMD_STATUS: begin
					for (int i = 0; i < NCH; i++) begin
						r.read_data[i] = completed[i];
						completed[i] = 0;
					end
					if (r.read_data != 8'h00)
						n_status++;
				end
				default: ;
			endcase
			r.terminal_count = (remaining[last] == 16'd0);
			owed.push_back(r);
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
				return;
			end
			want = owed.pop_front();
			compare("read_data", want.read_data, got.read_data);
			compare("hold_request", want.hold_request, got.hold_request);
			compare("grant_channel", want.grant_channel, got.grant_channel);
			compare("grant_address", want.grant_address, got.grant_address);
			compare("grant_kind", want.grant_kind, got.grant_kind);
			compare("channel_done", want.channel_done, got.channel_done);
			compare("terminal_count", want.terminal_count, got.terminal_count);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [1:0]  m_tuser;
	logic [31:0] m_tdata;

	channel_ledger ledger;
	int            send_idle_pct;
	int            recv_stall_pct;
	int            useful_requests;

	four_channel_dma_controller u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// receiver stalls at random
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// accepted requests and results are both taken at the rising edge
	always @(posedge clk) begin
		result_t seen;
		if (arst_n && s_tvalid && s_tready)
			ledger.note_request(cmd_t'(s_tuser), s_tdata[3:0], s_tdata[11:4], s_tdata[15:12]);
		if (arst_n && m_tvalid && m_tready) begin
			seen.read_data      = m_tdata[7:0];
			seen.hold_request   = m_tdata[8];
			seen.grant_channel  = m_tdata[10:9];
			seen.grant_address  = m_tdata[26:11];
			seen.channel_done   = m_tdata[27];
			seen.terminal_count = m_tdata[28];
			seen.grant_kind     = m_tuser;
			ledger.check_result(seen);
		end
	end

	// entered and left at a falling edge
	task automatic push_request(cmd_t c, logic [3:0] idx, logic [7:0] d, logic [3:0] rq);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {rq, d, idx};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		if (c != CMD_NOP && !(c == CMD_WRITE && idx > MODE_REG))
			useful_requests++;
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (ledger.owed.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] mode_byte(logic [3:0] en, bit rot, bit stop, logic [7:0] extra);
		logic [7:0] m;
		m = {4'h0, en} | (extra & (MODE_EXT_WRITE | MODE_AUTOLOAD));
		m[MODE_ROTATE_BIT] = rot;
		m[MODE_STOP_BIT]   = stop;
		return m;
	endfunction

	// address register of a channel sits at 2*ch, its count at 2*ch+1
	task automatic program_channel(int ch, logic [15:0] addr, logic [13:0] count, logic [1:0] k);
		push_request(CMD_WRITE, 4'(2 * ch), addr[7:0], 4'($urandom));
		push_request(CMD_WRITE, 4'(2 * ch), addr[15:8], 4'($urandom));
		push_request(CMD_WRITE, 4'(2 * ch + 1), count[7:0], 4'($urandom));
		push_request(CMD_WRITE, 4'(2 * ch + 1), {k, count[13:8]}, 4'($urandom));
	endtask

	task automatic directed_requests();
		push_request(CMD_TICK, 4'h0, 8'h00, 4'hf);            // nothing enabled yet
		push_request(CMD_STATUS, 4'h0, 8'h00, 4'h0);
		push_request(CMD_NOP, 4'hf, 8'hff, 4'hf);
		push_request(CMD_WRITE, 4'h9, 8'h55, 4'h0);            // unknown registers
		push_request(CMD_WRITE, 4'hf, 8'haa, 4'h0);
		push_request(CMD_WRITE, MODE_REG, mode_byte(4'h0, 0, 0, 8'hff), 4'h0);
		program_channel(0, 16'hffff, 14'h0000, KIND_VERIFY);   // one transfer, address wraps
		program_channel(3, 16'h8000, 14'h3fff, KIND_NONE);     // largest count
		push_request(CMD_WRITE, MODE_REG, mode_byte(4'h9, 0, 1, 8'h00), 4'h0);
		push_request(CMD_TICK, 4'h0, 8'h00, 4'hf);            // channel 0 finishes and stops
		push_request(CMD_TICK, 4'h0, 8'h00, 4'hf);
		push_request(CMD_STATUS, 4'h0, 8'h00, 4'h0);
		push_request(CMD_STATUS, 4'h0, 8'h00, 4'h0);
		push_request(CMD_WRITE, MODE_REG, mode_byte(4'hf, 1, 0, 8'h00), 4'h0);
		repeat (4)
			push_request(CMD_TICK, 4'h0, 8'h00, 4'hf);        // rotation, count wraps on channel 0
		push_request(CMD_WRITE, MODE_REG, 8'hff, 4'h0);
		push_request(CMD_TICK, 4'h0, 8'h00, 4'h0);
	endtask

	// mostly well-formed programming then a run of ticks, sometimes plain noise
	task automatic random_burst();
		logic [3:0]  en;
		logic [13:0] count;
		logic [1:0]  k;
		int          ch;
		if ($urandom_range(99) < 20) begin
			repeat ($urandom_range(1, 6))
				push_request(cmd_t'($urandom_range(3)), 4'($urandom), 8'($urandom),
					4'($urandom));
			return;
		end
		en = 4'($urandom);
		push_request(CMD_WRITE, MODE_REG, mode_byte(4'h0, 0, 0, 8'($urandom)), 4'($urandom));
		repeat ($urandom_range(1, 2)) begin
			ch = $urandom_range(NCH - 1);
			k  = 2'($urandom);
			if ($urandom_range(99) < 80)
				count = 14'($urandom_range(5));
			else
				count = 14'($urandom);
			program_channel(ch, 16'($urandom), count, k);
		end
		push_request(CMD_WRITE, MODE_REG,
			mode_byte(en, $urandom_range(1), $urandom_range(1), 8'($urandom)), 4'($urandom));
		repeat ($urandom_range(4, 16)) begin
			if ($urandom_range(99) < 12)
				push_request(CMD_STATUS, 4'($urandom), 8'($urandom), 4'($urandom));
			else
				push_request(CMD_TICK, 4'($urandom), 8'($urandom), 4'($urandom));
		end
		push_request(CMD_STATUS, 4'h0, 8'h00, 4'h0);
	endtask

	initial begin
		int target;
		ledger          = new();
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tuser         = CMD_NOP;
		s_tdata         = '0;
		m_tready        = 1'b0;
		send_idle_pct   = 13;
		recv_stall_pct  = 59;
		useful_requests = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_requests();
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct  = (ph == 0) ? 13 : (ph == 1) ? 59 : 0;
			recv_stall_pct = (ph == 0) ? 59 : (ph == 1) ? 13 : 0;
			target = useful_requests + PHASE_REQUESTS;
			while (useful_requests < target)
				random_burst();
			// sender holds off until every result is back
			wait_for_results();
		end
		repeat (8) @(negedge clk);

		$display("covered %0d requests: %0d grants, %0d channel completions, %0d nonzero status reads",
			useful_requests, ledger.n_grants, ledger.n_done, ledger.n_status);
		$display("three idling phases, fixed and rotating priority, stop on done and count wrap");
		if (ledger.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("run stalled before all results arrived");
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
